// ===== src/dsr_pkg.sv =====
// Package for the direction switch resist filter.
// Holds shared constants, register addresses, verdict codes, the sequencer
// state type and the history control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsr_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [12:0] MIN_MOVE_DEF = 13'd51;
  localparam logic [8:0]  AGGR_FULL    = 9'd256;

  localparam logic [PADDR_W-1:0] ADDR_MIN_MOVE   = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_AGGRESSION = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_FAST_ON    = 4'h8;

  localparam logic [2:0] VERDICT_PASS        = 3'd0;
  localparam logic [2:0] VERDICT_BELOW_MIN   = 3'd1;
  localparam logic [2:0] VERDICT_WEAK        = 3'd2;
  localparam logic [2:0] VERDICT_NOT_WORSE   = 3'd3;
  localparam logic [2:0] VERDICT_OVERSHOOT   = 3'd4;

  localparam logic ACTION_PROCESS = 1'b0;
  localparam logic ACTION_CLEAR   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;    // zero every entry
    logic shift;    // shift a new word in at the newest end
    logic rewrite;  // fast switch: older entries zero, newest three the sample
  } hist_ctl_t;

endpackage

`default_nettype wire

// ===== src/direction_switch_resist_filter_unit.sv =====
// Top level of the direction switch resist filter: stream ports, APB
// registers, sequencer and the shared scan accumulator.
// Depends on dsr_pkg and dsr_hist.
//
//   port group   dir   contents
//   s_*          in    tdata: error_sample[15:0]; tuser: action[0]
//   m_*          out   tdata: correction[15:0], direction[17:16], zero [23:18]
//                      tuser: verdict[2:0], forced_switch[3]
//   p*           in    APB registers min_move 0x0, aggression 0x4, fast_switch_on 0x8
//
// A sample passes ST_CHECK, ST_SCAN, ST_DECIDE, ST_MUL and ST_DONE; the scan walks
// one history entry per cycle through one adder pair. A clear goes from ST_IDLE
// straight to ST_DONE, and a sample below the minimum leaves ST_CHECK for ST_DONE.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register while m_tready is low, and the next result holds the
// sequencer in its last state until that register frees.
// Reset is synchronous and clears the history, the direction and the registers.
`timescale 1ns / 1ps
`default_nettype none

module direction_switch_resist_filter_unit #(
  parameter int HISTORY_DEPTH = dsr_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [15:0]                 s_tdata,   // error_sample[15:0]
  input  wire  [0:0]                  s_tuser,   // action[0]
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [23:0]                 m_tdata,   // correction[15:0], direction[17:16]
  output logic [3:0]                  m_tuser,   // verdict[2:0], forced_switch[3]
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [dsr_pkg::PADDR_W-1:0] paddr,
  input  wire  [dsr_pkg::PDATA_W-1:0] pwdata,
  output logic [dsr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int NET_W = $clog2(HISTORY_DEPTH + 1) + 1;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_NEWER = IDX_W'(HISTORY_DEPTH - 3);

  // Configuration registers.
  logic [12:0] min_move;
  logic [8:0]  aggression;
  logic        fast_switch_on;

  // Sequencer and datapath registers.
  dsr_pkg::state_t state, state_next;
  logic signed [1:0]       side;
  logic signed [15:0]      x;
  logic [IDX_W-1:0]        idx;
  logic signed [NET_W-1:0] net;
  logic signed [17:0]      oldest, newest;
  logic [2:0]              verdict;
  logic                    forced;
  logic signed [25:0]      prod;

  dsr_pkg::hist_ctl_t hctl;
  logic signed [15:0] hist_wr, hist_rd;
  logic               out_free, out_load;

  // ---------------- configuration port ----------------
  logic        wr_en;
  logic [12:0] wr_mm;
  logic [8:0]  wr_ag;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_mm  = pwdata[12:0];
  assign wr_ag  = pwdata[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_move       <= dsr_pkg::MIN_MOVE_DEF;
      aggression     <= dsr_pkg::AGGR_FULL;
      fast_switch_on <= 1'b1;
    end else if (wr_en) begin
      case (paddr)
        dsr_pkg::ADDR_MIN_MOVE:
          min_move <= (wr_mm == 13'd0) ? dsr_pkg::MIN_MOVE_DEF : wr_mm;
        dsr_pkg::ADDR_AGGRESSION:
          aggression <= (wr_ag == 9'd0 || wr_ag > dsr_pkg::AGGR_FULL) ?
                        dsr_pkg::AGGR_FULL : wr_ag;
        dsr_pkg::ADDR_FAST_ON:
          fast_switch_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      dsr_pkg::ADDR_MIN_MOVE:   prdata = {19'd0, min_move};
      dsr_pkg::ADDR_AGGRESSION: prdata = {23'd0, aggression};
      dsr_pkg::ADDR_FAST_ON:    prdata = {31'd0, fast_switch_on};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- sample checks ----------------
  logic signed [16:0] x_ext;
  logic [16:0]        abs_x;
  logic [14:0]        mm3;
  logic signed [1:0]  sgn_x;
  logic               below, fast;

  assign x_ext = {x[15], x};
  assign abs_x = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
  assign mm3   = {2'b00, min_move} + {1'b0, min_move, 1'b0};
  assign sgn_x = (x == 16'sd0) ? 2'sd0 : (x[15] ? -2'sd1 : 2'sd1);
  assign below = abs_x < {4'd0, min_move};
  assign fast  = fast_switch_on && (sgn_x != side) && (abs_x > {2'd0, mm3});

  // ---------------- scan accumulator ----------------
  logic signed [16:0]      e_ext;
  logic [16:0]             abs_e;
  logic signed [1:0]       sgn_e;
  logic                    in_old;
  logic signed [NET_W-1:0] net_sum;
  logic signed [17:0]      add_a, add_sum;

  assign e_ext  = {hist_rd[15], hist_rd};
  assign abs_e  = e_ext[16] ? 17'(-e_ext) : 17'(e_ext);
  assign sgn_e  = (hist_rd == 16'sd0) ? 2'sd0 : (hist_rd[15] ? -2'sd1 : 2'sd1);
  assign in_old = idx < IDX_W'(3);
  assign net_sum = (abs_e > {4'd0, min_move}) ?
                   net + {{(NET_W-2){sgn_e[1]}}, sgn_e} : net;
  assign add_a   = in_old ? oldest : newest;
  assign add_sum = add_a + {{2{hist_rd[15]}}, hist_rd};

  // ---------------- decision ----------------
  logic signed [1:0]  sgn_net;
  logic [NET_W-1:0]   abs_net;
  logic [17:0]        abs_old, abs_new;
  logic signed [1:0]  dec_side;
  logic [2:0]         dec_verdict;

  assign sgn_net = (net == '0) ? 2'sd0 : (net[NET_W-1] ? -2'sd1 : 2'sd1);
  assign abs_net = net[NET_W-1] ? NET_W'(-net) : NET_W'(net);
  assign abs_old = oldest[17] ? 18'(-oldest) : 18'(oldest);
  assign abs_new = newest[17] ? 18'(-newest) : 18'(newest);

  always_comb begin
    dec_side    = side;
    dec_verdict = dsr_pkg::VERDICT_PASS;
    if (side == 2'sd0 || side == -sgn_net) begin
      if (abs_net < NET_W'(3)) begin
        dec_verdict = dsr_pkg::VERDICT_WEAK;
      end else if (abs_new <= abs_old) begin
        dec_verdict = dsr_pkg::VERDICT_NOT_WORSE;
      end else begin
        dec_side = sgn_net;
      end
    end
    if (dec_verdict == dsr_pkg::VERDICT_PASS && dec_side != sgn_x) begin
      dec_verdict = dsr_pkg::VERDICT_OVERSHOOT;
    end
  end

  // ---------------- sequencer ----------------
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      dsr_pkg::ST_IDLE:
        if (s_tvalid) begin
          state_next = (s_tuser[0] == dsr_pkg::ACTION_CLEAR) ?
                       dsr_pkg::ST_DONE : dsr_pkg::ST_CHECK;
        end
      dsr_pkg::ST_CHECK:  state_next = below ? dsr_pkg::ST_DONE : dsr_pkg::ST_SCAN;
      dsr_pkg::ST_SCAN:   if (idx == IDX_LAST) state_next = dsr_pkg::ST_DECIDE;
      dsr_pkg::ST_DECIDE: state_next = dsr_pkg::ST_MUL;
      dsr_pkg::ST_MUL:    state_next = dsr_pkg::ST_DONE;
      dsr_pkg::ST_DONE:   if (out_free) state_next = dsr_pkg::ST_IDLE;
      default:            state_next = dsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == dsr_pkg::ST_IDLE);
    hctl.clear   = s_tready && s_tvalid && (s_tuser[0] == dsr_pkg::ACTION_CLEAR);
    hctl.shift   = s_tready && s_tvalid && (s_tuser[0] == dsr_pkg::ACTION_PROCESS);
    hctl.rewrite = (state == dsr_pkg::ST_CHECK) && !below && fast;
    hist_wr      = s_tready ? $signed(s_tdata) : x;
    out_load     = (state == dsr_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsr_pkg::ST_IDLE;
      side  <= 2'sd0;
    end else begin
      state <= state_next;
      case (state)
        dsr_pkg::ST_IDLE:
          if (s_tvalid && s_tuser[0] == dsr_pkg::ACTION_CLEAR) begin
            side <= 2'sd0;
          end else if (wr_en && paddr == dsr_pkg::ADDR_MIN_MOVE && wr_mm != 13'd0) begin
            side <= 2'sd0;
          end
        dsr_pkg::ST_CHECK:
          if (!below && fast) side <= 2'sd0;
        dsr_pkg::ST_DECIDE:
          side <= dec_side;
        default: ;
      endcase
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    case (state)
      dsr_pkg::ST_IDLE:
        if (s_tvalid) begin
          x       <= $signed(s_tdata);
          verdict <= dsr_pkg::VERDICT_PASS;
          forced  <= 1'b0;
          prod    <= '0;
        end
      dsr_pkg::ST_CHECK: begin
        verdict <= below ? dsr_pkg::VERDICT_BELOW_MIN : dsr_pkg::VERDICT_PASS;
        forced  <= !below && fast;
        idx     <= '0;
        net     <= '0;
        oldest  <= '0;
        newest  <= '0;
      end
      dsr_pkg::ST_SCAN: begin
        net <= net_sum;
        if (in_old) oldest <= add_sum;
        else if (idx >= IDX_NEWER) newest <= add_sum;
        if (idx != IDX_LAST) idx <= idx + 1'b1;
      end
      dsr_pkg::ST_DECIDE:
        verdict <= dec_verdict;
      dsr_pkg::ST_MUL:
        prod <= x * $signed({1'b0, aggression});
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic signed [15:0] corr;
  assign corr = (verdict == dsr_pkg::VERDICT_PASS) ? prod[23:8] : 16'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, side, corr};
      m_tuser <= {forced, verdict};
    end
  end

  dsr_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .wr_data (hist_wr),
    .rd_idx  (idx),
    .rd_data (hist_rd)
  );

  // ---------------- assertions ----------------
  a_side_legal: assert property (@(posedge clk) disable iff (rst)
    side != 2'sb10) else $error("committed direction holds an illegal code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("a second word was taken while one is in flight");

  a_veto_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:0] != dsr_pkg::VERDICT_PASS) |-> (m_tdata[15:0] == 16'd0))
    else $error("vetoed word carries a nonzero correction");

  a_forced_not_below: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] != dsr_pkg::VERDICT_BELOW_MIN))
    else $error("fast switch reported on a sample below the minimum");

endmodule

`default_nettype wire

// ===== src/dsr_hist.sv =====
// Error history shift line with a single indexed read port.
// Depends on dsr_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module dsr_hist #(
  parameter int HISTORY_DEPTH = dsr_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  dsr_pkg::hist_ctl_t         ctl,
  input  wire  signed [15:0]               wr_data,
  input  wire  [$clog2(HISTORY_DEPTH)-1:0] rd_idx,
  output logic signed [15:0]               rd_data
);

  logic signed [15:0] hist [HISTORY_DEPTH];

  // Index 0 is the oldest entry.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
    end else if (ctl.rewrite) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= (i < HISTORY_DEPTH - 3) ? 16'sd0 : wr_data;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist[i] <= hist[i+1];
      hist[HISTORY_DEPTH-1] <= wr_data;
    end
  end

  assign rd_data = hist[rd_idx];

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for direction_switch_resist_filter_unit.
// Drives guide error words and APB register writes, predicts each result word
// in a scoreboard class and compares it field by field. Depends on dsr_pkg.
`timescale 1ns / 1ps

module testbench;
  import dsr_pkg::*;

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 4'hC;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_HEAVY = 84;
  localparam int IDLE_LIGHT = 15;

  typedef struct packed {
    logic signed [15:0] correction;
    logic signed [1:0]  direction;
    logic [2:0]         verdict;
    logic               forced;
  } guide_result_t;

  class guide_filter_scoreboard;
    int min_move = MIN_MOVE_DEF;
    int aggression = AGGR_FULL;
    bit fast_on = 1'b1;
    int hist[DEPTH];
    int side;
    guide_result_t expected_q[$];
    int unsigned mismatches;

    function int abs_of(int v);
      return (v < 0) ? -v : v;
    endfunction

    function int sign_of(int v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void apply_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
      case (addr)
        ADDR_MIN_MOVE: begin
          // Zero loads the default and keeps the direction.
          if (value[12:0] == '0) begin
            min_move = MIN_MOVE_DEF;
          end else begin
            min_move = value[12:0];
            side = 0;
          end
        end
        ADDR_AGGRESSION: begin
          if (value[8:0] == '0 || value[8:0] > AGGR_FULL) aggression = AGGR_FULL;
          else aggression = value[8:0];
        end
        ADDR_FAST_ON: fast_on = value[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [PADDR_W-1:0] addr);
      case (addr)
        ADDR_MIN_MOVE:   return 32'(min_move);
        ADDR_AGGRESSION: return 32'(aggression);
        ADDR_FAST_ON:    return 32'(fast_on);
        default:         return '0;
      endcase
    endfunction

    function void note_input(logic act, logic signed [15:0] smp);
      guide_result_t r;
      int x, sx, net, oldest, newest, i;
      r = '0;
      x = smp;
      sx = sign_of(x);
      if (act == ACTION_CLEAR) begin
        for (i = 0; i < DEPTH; i++) hist[i] = 0;
        side = 0;
      end else begin
        for (i = 0; i < DEPTH - 1; i++) hist[i] = hist[i + 1];
        hist[DEPTH - 1] = x;
        if (abs_of(x) < min_move) begin
          r.verdict = VERDICT_BELOW_MIN;
        end else begin
          // A large reversal drops the direction and seeds the newest three entries.
          if (fast_on && sx != side && abs_of(x) > 3 * min_move) begin
            side = 0;
            for (i = 0; i < DEPTH; i++) hist[i] = (i < DEPTH - 3) ? 0 : x;
            r.forced = 1'b1;
          end
          net = 0;
          for (i = 0; i < DEPTH; i++)
            if (abs_of(hist[i]) > min_move) net += sign_of(hist[i]);
          if (side == 0 || side == -sign_of(net)) begin
            if (abs_of(net) < 3) begin
              r.verdict = VERDICT_WEAK;
            end else begin
              oldest = 0;
              newest = 0;
              for (i = 0; i < 3; i++) begin
                oldest += hist[i];
                newest += hist[DEPTH - 1 - i];
              end
              if (abs_of(newest) <= abs_of(oldest)) r.verdict = VERDICT_NOT_WORSE;
              else side = sign_of(net);
            end
          end
          if (r.verdict == VERDICT_PASS && side != sx) r.verdict = VERDICT_OVERSHOOT;
          if (r.verdict == VERDICT_PASS) r.correction = 16'((x * aggression) >>> 8);
        end
      end
      r.direction = 2'(side);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] tdata, logic [3:0] tuser);
      guide_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: tdata %h tuser %h", tdata, tuser);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (tdata[15:0] !== e.correction) begin
        $error("correction: expected %0d, got %0d", e.correction, $signed(tdata[15:0]));
        mismatches++;
      end
      if (tdata[17:16] !== e.direction) begin
        $error("direction: expected %0d, got %0d", e.direction, $signed(tdata[17:16]));
        mismatches++;
      end
      if (tuser[2:0] !== e.verdict) begin
        $error("verdict: expected %0d, got %0d", e.verdict, tuser[2:0]);
        mismatches++;
      end
      if (tuser[3] !== e.forced) begin
        $error("forced_switch: expected %0d, got %0d", e.forced, tuser[3]);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;   // error_sample[15:0]
  logic [0:0]          s_tuser = '0;   // action[0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;        // correction[15:0], direction[17:16]
  logic [3:0]          m_tuser;        // verdict[2:0], forced_switch[3]
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  guide_filter_scoreboard sb = new;
  int tx_idle_pct = IDLE_NONE;
  int rx_stall_pct = IDLE_NONE;
  int holds_asked = 0;
  int holds_done = 0;
  int run_sign = 1;

  direction_switch_resist_filter_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("** direction_switch_resist_filter_unit: FAILED **");
    $finish;
  end

  task automatic offer_word(input logic act, input logic [15:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register, then read it back unless the address is unmapped.
  task automatic set_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.apply_write(addr, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_UNMAPPED) begin
      psel <= 1'b0;
    end else begin
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== sb.reg_value(addr)) begin
        $error("register %h: expected %0d, got %0d", addr, sb.reg_value(addr), got);
        sb.mismatches++;
      end
    end
    @(posedge clk);
  endtask

  // Mostly runs of same-sign errors above the minimum, with reversals, small
  // errors and raw noise mixed in.
  function automatic logic [15:0] next_error(int mm);
    int kind, mag, top, sgn;
    kind = $urandom_range(99);
    top = (4 * mm > 32767) ? 32767 : 4 * mm;
    sgn = run_sign;
    if (kind < 12) return 16'($urandom);
    if (kind < 25) begin
      mag = $urandom_range(mm - 1);
      sgn = $urandom_range(1) ? 1 : -1;
    end else if (kind < 33 && 3 * mm < 32767) begin
      mag = $urandom_range(32767, 3 * mm + 1);
      run_sign = -run_sign;
      sgn = run_sign;
    end else begin
      if ($urandom_range(7) == 0) run_sign = -run_sign;
      sgn = run_sign;
      mag = $urandom_range(top, mm);
    end
    return 16'(sgn * mag);
  endfunction

  initial begin
    int p, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_word(ACTION_CLEAR, 16'hA5A5);
    offer_word(ACTION_PROCESS, 16'h0000);
    repeat (3) offer_word(ACTION_PROCESS, 16'd100);
    offer_word(ACTION_PROCESS, 16'd120);
    offer_word(ACTION_PROCESS, 16'(-100));
    offer_word(ACTION_PROCESS, 16'h8000);
    offer_word(ACTION_PROCESS, 16'h7FFF);
    offer_word(ACTION_PROCESS, 16'hFFFF);
    wait_drained();
    set_reg(ADDR_FAST_ON, 32'd0);
    set_reg(ADDR_AGGRESSION, 32'd1);
    offer_word(ACTION_CLEAR, 16'h0000);
    repeat (3) offer_word(ACTION_PROCESS, 16'd300);
    repeat (7) offer_word(ACTION_PROCESS, 16'd52);
    wait_drained();
    // Rewriting the minimum drops the direction but keeps the history, so
    // a weaker newest run is refused as not getting worse.
    set_reg(ADDR_MIN_MOVE, 32'd51);
    offer_word(ACTION_PROCESS, 16'd52);
    wait_drained();
    set_reg(ADDR_MIN_MOVE, 32'd0);
    set_reg(ADDR_AGGRESSION, 32'd0);
    set_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    set_reg(ADDR_AGGRESSION, 32'd300);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          set_reg(ADDR_MIN_MOVE, 32'd51);
          set_reg(ADDR_AGGRESSION, 32'd256);
          set_reg(ADDR_FAST_ON, 32'd1);
        end
        1: begin
          set_reg(ADDR_MIN_MOVE, 32'd1);
          set_reg(ADDR_AGGRESSION, 32'd1);
          set_reg(ADDR_FAST_ON, 32'd1);
        end
        2: begin
          set_reg(ADDR_MIN_MOVE, 32'd5120);
          set_reg(ADDR_AGGRESSION, 32'd255);
          set_reg(ADDR_FAST_ON, 32'd0);
        end
        3: begin
          set_reg(ADDR_MIN_MOVE, 32'd8191);
          set_reg(ADDR_AGGRESSION, 32'd128);
          set_reg(ADDR_FAST_ON, 32'd1);
        end
        4: begin
          set_reg(ADDR_MIN_MOVE, 32'($urandom_range(600, 1)));
          set_reg(ADDR_AGGRESSION, 32'($urandom_range(256, 1)));
          set_reg(ADDR_FAST_ON, 32'($urandom_range(1)));
        end
        default: begin
          set_reg(ADDR_MIN_MOVE, 32'd40);
          set_reg(ADDR_AGGRESSION, 32'd200);
          set_reg(ADDR_FAST_ON, 32'd1);
        end
      endcase
      case (p % 4)
        0: begin tx_idle_pct = IDLE_NONE;  rx_stall_pct = IDLE_NONE;  end
        1: begin tx_idle_pct = IDLE_HEAVY; rx_stall_pct = IDLE_NONE;  end
        2: begin tx_idle_pct = IDLE_NONE;  rx_stall_pct = IDLE_HEAVY; end
        default: begin tx_idle_pct = IDLE_LIGHT; rx_stall_pct = IDLE_LIGHT; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 0 && n == 60) holds_asked++;
        if (n == ITEMS_PER_PHASE / 2) wait_drained();
        if ($urandom_range(99) < 3) offer_word(ACTION_CLEAR, 16'($urandom));
        else offer_word(ACTION_PROCESS, next_error(sb.min_move));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected result words never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) $display("** direction_switch_resist_filter_unit: PASSED **");
    else $display("** direction_switch_resist_filter_unit: FAILED **");
    $finish;
  end

endmodule
